>>> src/crpsta_pkg.sv
// Shared widths, types and helpers for the trapezoid CRPS accumulator.
// Used by crps_trapezoid_accumulator and its checker; depends on nothing.
package crpsta_pkg;

	localparam int VALUE_W    = 32;
	localparam int PROB_FRAC  = 16;
	localparam int PROB_W     = PROB_FRAC + 1;
	localparam int WID_W      = VALUE_W + 1;
	localparam int SCORE_W    = VALUE_W - 1;
	localparam int ACC_W      = 64;

	// Shared multiplier: wide enough for a probability square in one pass.
	localparam int MUL_W      = PROB_FRAC + 2;
	// Doubled height (a*a + b*b) never needs more than two multiplier chunks.
	localparam int H2_W       = 2 * PROB_FRAC + 2;
	localparam int H2_CHUNKS  = 2;
	localparam int MAG_CHUNKS = (WID_W + MUL_W - 1) / MUL_W;
	localparam int MC_W       = (MAG_CHUNKS > 1) ? $clog2(MAG_CHUNKS) : 1;
	localparam int PROD_W     = (MAG_CHUNKS + H2_CHUNKS) * MUL_W;
	localparam int TERM_SHIFT = 2 * PROB_FRAC + 1;
	localparam int RND_W      = PROD_W - TERM_SHIFT;

	typedef logic [PROB_W-1:0]         prob_t;
	typedef logic signed [VALUE_W-1:0] value_t;
	typedef logic signed [WID_W-1:0]   width_t;
	typedef logic signed [ACC_W-1:0]   acc_t;

	// One bin term: width times doubled height, height from a (and b if cont).
	typedef struct packed {
		width_t w;
		prob_t  a;
		prob_t  b;
		logic   cont;
	} term_t;

	localparam prob_t P_ONE = {1'b1, {PROB_FRAC{1'b0}}};
	localparam acc_t  ACC_LIM = {2'b01, {(ACC_W-2){1'b0}}};
	localparam logic [SCORE_W-1:0] SCORE_MAX = '1;

	function automatic prob_t clamp_prob(prob_t v);
		return (v > P_ONE) ? P_ONE : v;
	endfunction

endpackage

>>> src/crps_trapezoid_accumulator.sv
// Top level of the trapezoid CRPS accumulator: sequencer around one shared multiplier.
// Depends on crpsta_pkg.
//
//   channel | direction | handshake            | payload
//   --------+-----------+----------------------+-------------------------------------------
//   in      | sink      | in_valid / in_stall  | grid_quantile grid_prob prob_missing
//           |           |                      | observation obs_cdf first_point last_point
//   out     | source    | out_valid/ out_stall | score saturated
//   cfg     | sink      | cfg_wr_en            | cfg_wr_data (continuous_mode)
//
// Per item: S_SETUP; per bin term (a split bin gives two) S_SQA, S_SQB in continuous
// mode only, S_MUL, S_RND, S_ACC; then S_TAIL, and for the last point S_ACC, S_DONE.
// The single MUL_W x MUL_W multiplier does one square (two in continuous mode) and
// four partial products per bin term. Reset is asynchronous, active low, and leaves
// continuous mode on with control state zero. A stalled result sits in the output
// register; the next item is still taken and waits only in S_DONE.
module crps_trapezoid_accumulator
	import crpsta_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_wr_en,
	input  logic               cfg_wr_data,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [VALUE_W-1:0] grid_quantile,
	input  logic [PROB_W-1:0]  grid_prob,
	input  logic               prob_missing,
	input  logic [VALUE_W-1:0] observation,
	input  logic [PROB_W-1:0]  obs_cdf,
	input  logic               first_point,
	input  logic               last_point,
	output logic               out_valid,
	input  logic               out_stall,
	output logic [SCORE_W-1:0] score,
	output logic               saturated
);

	localparam logic [3:0] S_IDLE  = 4'd0;
	localparam logic [3:0] S_SETUP = 4'd1;
	localparam logic [3:0] S_SQA   = 4'd2;
	localparam logic [3:0] S_SQB   = 4'd3;
	localparam logic [3:0] S_MUL   = 4'd4;
	localparam logic [3:0] S_RND   = 4'd5;
	localparam logic [3:0] S_ACC   = 4'd6;
	localparam logic [3:0] S_TAIL  = 4'd7;
	localparam logic [3:0] S_DONE  = 4'd8;

	logic [3:0]      state_q;
	logic            cont_mode_q;
	value_t          prev_quantile_q;
	prob_t           prev_prob_q;
	value_t          first_quantile_q;
	acc_t            sum_q;
	logic            nxt_valid_q;
	logic            in_tail_q;
	logic [MC_W-1:0] mc_q;
	logic            hc_q;
	logic            out_valid_q;

	value_t          q_q;
	prob_t           p_q;
	logic            miss_q;
	value_t          x_q;
	prob_t           px_q;
	logic            first_q;
	logic            last_q;
	term_t           cur_q;
	term_t           nxt_q;
	logic [H2_W-1:0] h2_q;
	logic [WID_W-1:0] mag_q;
	logic            neg_q;
	logic [PROD_W-1:0] prod_q;
	acc_t            t_q;
	logic [SCORE_W-1:0] score_q;
	logic            sat_q;

	logic            in_acc;
	logic            out_free;

	// Bin terms formed from the captured item and the previous point.
	width_t          w_q_lo;
	width_t          w_x_lo;
	width_t          w_q_x;
	term_t           t0;
	term_t           t1;
	logic            two_terms;
	logic            has_bin;

	logic [MUL_W-1:0]            mul_a;
	logic [MUL_W-1:0]            mul_b;
	logic [2*MUL_W-1:0]          mul_p;
	logic [MAG_CHUNKS*MUL_W-1:0] mag_pad;
	logic [H2_CHUNKS*MUL_W-1:0]  h2_pad;
	logic [PROD_W-1:0]           pp_shift;
	logic [PROD_W-1:0]           rnd_sum;
	logic [RND_W-1:0]            rnd_val;
	acc_t                        rnd_ext;
	logic signed [ACC_W:0]       acc_sum;
	acc_t                        acc_next;
	width_t                      tail_amt;
	logic                        sum_big;

	assign in_acc   = in_valid && !in_stall;
	assign in_stall = (state_q != S_IDLE);
	assign out_free = !out_valid_q || !out_stall;

	always_comb begin
		w_q_lo    = WID_W'(q_q) - WID_W'(prev_quantile_q);
		w_x_lo    = WID_W'(x_q) - WID_W'(prev_quantile_q);
		w_q_x     = WID_W'(q_q) - WID_W'(x_q);
		has_bin   = !first_q && !miss_q;
		two_terms = 1'b0;
		t1        = '{w: w_q_x, a: P_ONE - px_q, b: '0, cont: 1'b0};
		if (q_q <= x_q) begin
			t0 = '{w: w_q_lo, a: prev_prob_q, b: p_q, cont: cont_mode_q};
		end else if (prev_quantile_q >= x_q) begin
			t0 = '{w: w_q_lo, a: P_ONE - prev_prob_q, b: P_ONE - p_q, cont: cont_mode_q};
		end else begin
			// The observation lies inside the bin: split it there.
			t0        = '{w: w_x_lo, a: prev_prob_q, b: px_q, cont: cont_mode_q};
			two_terms = 1'b1;
			if (cont_mode_q) begin
				t1 = '{w: w_q_x, a: P_ONE - p_q, b: P_ONE - px_q, cont: 1'b1};
			end
		end
	end

	always_comb begin
		mag_pad = (MAG_CHUNKS*MUL_W)'(mag_q);
		h2_pad  = (H2_CHUNKS*MUL_W)'(h2_q);
		case (state_q)
			S_SQA: begin
				mul_a = MUL_W'(cur_q.a);
				mul_b = MUL_W'(cur_q.a);
			end
			S_SQB: begin
				mul_a = MUL_W'(cur_q.b);
				mul_b = MUL_W'(cur_q.b);
			end
			S_MUL: begin
				mul_a = mag_pad[int'(mc_q)*MUL_W +: MUL_W];
				mul_b = h2_pad[int'(hc_q)*MUL_W +: MUL_W];
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
		mul_p    = mul_a * mul_b;
		pp_shift = PROD_W'(mul_p) << ((int'(mc_q) + int'(hc_q)) * MUL_W);
	end

	always_comb begin
		rnd_sum = prod_q + (PROD_W'(1) << (TERM_SHIFT - 1));
		rnd_val = rnd_sum[PROD_W-1:TERM_SHIFT];
		rnd_ext = acc_t'(rnd_val);
		acc_sum = {sum_q[ACC_W-1], sum_q} + {t_q[ACC_W-1], t_q};
		if (acc_sum > (ACC_W+1)'(ACC_LIM)) begin
			acc_next = ACC_LIM;
		end else if (acc_sum < -((ACC_W+1)'(ACC_LIM))) begin
			acc_next = -ACC_LIM;
		end else begin
			acc_next = acc_sum[ACC_W-1:0];
		end
		if (x_q < first_quantile_q) begin
			tail_amt = WID_W'(first_quantile_q) - WID_W'(x_q);
		end else if (x_q > q_q) begin
			tail_amt = WID_W'(x_q) - WID_W'(q_q);
		end else begin
			tail_amt = '0;
		end
		sum_big = !sum_q[ACC_W-1] && (|sum_q[ACC_W-2:SCORE_W]);
	end

	// Control and architectural state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q          <= S_IDLE;
			cont_mode_q      <= 1'b1;
			prev_quantile_q  <= '0;
			prev_prob_q      <= '0;
			first_quantile_q <= '0;
			sum_q            <= '0;
			nxt_valid_q      <= 1'b0;
			in_tail_q        <= 1'b0;
			mc_q             <= '0;
			hc_q             <= 1'b0;
			out_valid_q      <= 1'b0;
		end else begin
			if (cfg_wr_en) begin
				cont_mode_q <= cfg_wr_data;
			end
			if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (in_acc) begin
						state_q <= S_SETUP;
					end
				end
				S_SETUP: begin
					prev_quantile_q <= q_q;
					prev_prob_q     <= p_q;
					if (first_q) begin
						first_quantile_q <= q_q;
						sum_q            <= '0;
					end
					nxt_valid_q <= has_bin && two_terms;
					in_tail_q   <= 1'b0;
					state_q     <= has_bin ? S_SQA : S_TAIL;
				end
				S_SQA: begin
					mc_q    <= '0;
					hc_q    <= 1'b0;
					state_q <= cur_q.cont ? S_SQB : S_MUL;
				end
				S_SQB: begin
					state_q <= S_MUL;
				end
				S_MUL: begin
					hc_q <= ~hc_q;
					if (hc_q) begin
						if (mc_q == MC_W'(MAG_CHUNKS - 1)) begin
							state_q <= S_RND;
						end else begin
							mc_q <= mc_q + 1'b1;
						end
					end
				end
				S_RND: begin
					state_q <= S_ACC;
				end
				S_ACC: begin
					sum_q <= acc_next;
					if (nxt_valid_q) begin
						nxt_valid_q <= 1'b0;
						state_q     <= S_SQA;
					end else if (in_tail_q) begin
						state_q <= S_DONE;
					end else begin
						state_q <= S_TAIL;
					end
				end
				S_TAIL: begin
					if (last_q) begin
						in_tail_q <= 1'b1;
						state_q   <= S_ACC;
					end else begin
						state_q <= S_IDLE;
					end
				end
				S_DONE: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						state_q     <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Datapath registers.
	always_ff @(posedge clk) begin
		if (in_acc) begin
			q_q     <= value_t'(grid_quantile);
			p_q     <= clamp_prob(grid_prob);
			miss_q  <= prob_missing;
			x_q     <= value_t'(observation);
			px_q    <= clamp_prob(obs_cdf);
			first_q <= first_point;
			last_q  <= last_point;
		end
		case (state_q)
			S_SETUP: begin
				cur_q <= t0;
				nxt_q <= t1;
			end
			S_SQA: begin
				h2_q   <= cur_q.cont ? H2_W'(mul_p) : (H2_W'(mul_p) << 1);
				neg_q  <= cur_q.w[WID_W-1];
				mag_q  <= cur_q.w[WID_W-1] ? WID_W'(-cur_q.w) : WID_W'(cur_q.w);
				prod_q <= '0;
			end
			S_SQB: begin
				h2_q <= h2_q + H2_W'(mul_p);
			end
			S_MUL: begin
				prod_q <= prod_q + pp_shift;
			end
			S_RND: begin
				t_q <= neg_q ? -rnd_ext : rnd_ext;
			end
			S_ACC: begin
				if (nxt_valid_q) begin
					cur_q <= nxt_q;
				end
			end
			S_TAIL: begin
				t_q <= acc_t'(tail_amt);
			end
			S_DONE: begin
				if (out_free) begin
					if (sum_q[ACC_W-1]) begin
						score_q <= '0;
						sat_q   <= 1'b1;
					end else if (sum_big) begin
						score_q <= SCORE_MAX;
						sat_q   <= 1'b1;
					end else begin
						score_q <= sum_q[SCORE_W-1:0];
						sat_q   <= 1'b0;
					end
				end
			end
			default: begin
			end
		endcase
	end

	assign out_valid = out_valid_q;
	assign score     = score_q;
	assign saturated = sat_q;

endmodule

>>> src/crpsta_checker.sv
// Port-level checks for crps_trapezoid_accumulator, attached by the bind below.
// Depends on crpsta_pkg and on the top level's port names.
module crpsta_checker
	import crpsta_pkg::*;
(
	input logic               clk,
	input logic               arst_n,
	input logic               in_valid,
	input logic               in_stall,
	input logic               out_valid,
	input logic               out_stall,
	input logic [SCORE_W-1:0] score,
	input logic               saturated
);

	// Taking an item makes the sequencer busy, which raises in_stall.
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> in_stall)
		else $error("input taken again right after an item");

	// A result is only produced from the final step of a running item.
	a_result_from_work: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_stall))
		else $error("result appeared while the sequencer was idle");

	// A clipped score sits at one end of the range.
	a_sat_clip: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && saturated) |-> (score == '0 || score == SCORE_MAX))
		else $error("saturated score is not at a range limit");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_stall) |=> (out_valid && $stable(score) && $stable(saturated)))
		else $error("stalled result changed");

endmodule

bind crps_trapezoid_accumulator crpsta_checker u_crpsta_checker (.*);

>>> tb/crps_trapezoid_accumulator_tb.sv
// Self-checking bench for crps_trapezoid_accumulator: directed forecasts, then random
// forecasts and noise, with an in-bench score predictor and in-order result checking.
// Depends on crpsta_pkg and the accumulator RTL.
module crps_trapezoid_accumulator_tb;
	import crpsta_pkg::*;

	localparam int          STUCK_LIMIT = 5000;
	localparam int          SETTLE      = 32;
	localparam int          AREA_SHIFT  = 2 * PROB_FRAC + 1;
	localparam logic [63:0] UNIT_PROB   = 64'd1 << PROB_FRAC;
	localparam int          UNIT_INT    = 1 << PROB_FRAC;
	localparam int          PROB_TOP    = (1 << PROB_W) - 1;
	localparam longint      SUM_LIM     = 64'sh4000_0000_0000_0000;
	localparam longint      SCORE_TOP   = (longint'(1) << SCORE_W) - 1;
	localparam value_t      ONE_Q       = 32'sh0001_0000;
	localparam value_t      V_MIN       = 32'sh8000_0000;
	localparam value_t      V_MAX       = 32'sh7fff_ffff;

	typedef struct packed {
		value_t quantile;
		prob_t  prob;
		logic   missing;
		value_t obs;
		prob_t  obs_prob;
		logic   first;
		logic   last;
	} grid_point_t;

	typedef struct packed {
		logic [SCORE_W-1:0] score;
		logic               clipped;
	} score_t;

	// Tracks one forecast at a time and keeps the scores still owed by the block.
	class crps_tracker_t;
		bit          trapezoid;
		longint      last_q;
		longint      first_q;
		longint      run_sum;
		logic [63:0] last_p;
		score_t      pending_scores[$];
		int          mismatches;

		function new();
			trapezoid = 1'b1;
			last_q = 0;
			first_q = 0;
			run_sum = 0;
			last_p = '0;
			mismatches = 0;
		endfunction

		function logic [63:0] clip_prob(prob_t v);
			return (v > UNIT_PROB) ? UNIT_PROB : 64'(v);
		endfunction

		function logic [63:0] height_x2(logic [63:0] a, logic [63:0] b, bit trap);
			return trap ? a * a + b * b : 2 * a * a;
		endfunction

		// Width times doubled height, scaled to Q16.16 and rounded half away from zero.
		function longint bin_area(longint w, logic [63:0] h2);
			logic [63:0]  mag;
			logic [127:0] prod;
			logic [63:0]  area;
			mag = (w < 0) ? -w : w;
			prod = {64'd0, mag} * {64'd0, h2};
			prod = prod + (128'd1 << (AREA_SHIFT - 1));
			area = prod[AREA_SHIFT +: 64];
			return (w < 0) ? -longint'(area) : longint'(area);
		endfunction

		function void add_area(longint t);
			run_sum = run_sum + t;
			if (run_sum > SUM_LIM)
				run_sum = SUM_LIM;
			if (run_sum < -SUM_LIM)
				run_sum = -SUM_LIM;
		endfunction

		function void take_point(grid_point_t pt);
			longint      q;
			longint      x;
			logic [63:0] p;
			logic [63:0] px;
			score_t      res;
			q = longint'($signed(pt.quantile));
			x = longint'($signed(pt.obs));
			p = clip_prob(pt.prob);
			px = clip_prob(pt.obs_prob);
			if (pt.first) begin
				run_sum = 0;
				first_q = q;
			end else if (!pt.missing) begin
				if (q <= x) begin
					add_area(bin_area(q - last_q, height_x2(last_p, p, trapezoid)));
				end else if (last_q >= x) begin
					add_area(bin_area(q - last_q,
						height_x2(UNIT_PROB - last_p, UNIT_PROB - p, trapezoid)));
				end else begin
					// The bin straddles the observation, so it is cut there.
					add_area(bin_area(x - last_q, height_x2(last_p, px, trapezoid)));
					if (trapezoid)
						add_area(bin_area(q - x,
							height_x2(UNIT_PROB - p, UNIT_PROB - px, 1'b1)));
					else
						add_area(bin_area(q - x, height_x2(UNIT_PROB - px, 0, 1'b0)));
				end
			end
			last_q = q;
			last_p = p;
			if (pt.last) begin
				if (x < first_q)
					add_area(first_q - x);
				else if (x > q)
					add_area(x - q);
				if (run_sum < 0) begin
					res.score = '0;
					res.clipped = 1'b1;
				end else if (run_sum > SCORE_TOP) begin
					res.score = '1;
					res.clipped = 1'b1;
				end else begin
					res.score = run_sum[SCORE_W-1:0];
					res.clipped = 1'b0;
				end
				pending_scores.push_back(res);
			end
		endfunction

		task report(string what);
			mismatches++;
			if (mismatches <= 40)
				$display("mismatch: %s", what);
		endtask

		task check_score(logic [SCORE_W-1:0] s, logic c);
			score_t want;
			if (pending_scores.size() == 0) begin
				report($sformatf("score %0d arrived with none outstanding", s));
			end else begin
				want = pending_scores.pop_front();
				if (s !== want.score)
					report($sformatf("score %0d, predicted %0d", s, want.score));
				if (c !== want.clipped)
					report($sformatf("saturated %b, predicted %b", c, want.clipped));
			end
		endtask
	endclass

	logic               clk = 1'b0;
	logic               arst_n;
	logic               cfg_wr_en;
	logic               cfg_wr_data;
	logic               in_valid;
	logic               in_stall;
	logic [VALUE_W-1:0] grid_quantile;
	logic [PROB_W-1:0]  grid_prob;
	logic               prob_missing;
	logic [VALUE_W-1:0] observation;
	logic [PROB_W-1:0]  obs_cdf;
	logic               first_point;
	logic               last_point;
	logic               out_valid;
	logic               out_stall;
	logic [SCORE_W-1:0] score;
	logic               saturated;

	crps_tracker_t tracker;
	grid_point_t   seen;
	int            points_sent = 0;
	int            burst_left = 0;
	int            stuck_cycles = 0;
	int            stall_run = 0;
	bit            stall_on = 1'b0;

	crps_trapezoid_accumulator u_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_wr_en     (cfg_wr_en),
		.cfg_wr_data   (cfg_wr_data),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.grid_quantile (grid_quantile),
		.grid_prob     (grid_prob),
		.prob_missing  (prob_missing),
		.observation   (observation),
		.obs_cdf       (obs_cdf),
		.first_point   (first_point),
		.last_point    (last_point),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.score         (score),
		.saturated     (saturated)
	);

	always #6 clk = ~clk;

	// Both channels are sampled with the values they held just before the edge.
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && !in_stall) begin
				seen = {grid_quantile, grid_prob, prob_missing, observation, obs_cdf,
					first_point, last_point};
				tracker.take_point(seen);
			end
			if (out_valid && !out_stall)
				tracker.check_score(score, saturated);
		end
	end

	// Receiver alternates stalled and free runs; some stall runs are skipped outright.
	always @(posedge clk) begin
		if (stall_run == 0) begin
			stall_on = !stall_on;
			if (stall_on && $urandom_range(0, 3) == 0)
				stall_on = 1'b0;
			stall_run = stall_on ? $urandom_range(1, 12) : $urandom_range(1, 40);
		end
		stall_run--;
		out_stall <= stall_on;
	end

	always @(posedge clk) begin
		if (!arst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
			stuck_cycles = 0;
		end else begin
			stuck_cycles++;
			if (stuck_cycles >= STUCK_LIMIT) begin
				$display("tb: failure");
				$finish;
			end
		end
	end

	function automatic grid_point_t make_point(value_t q, prob_t p, bit miss, value_t x,
			prob_t px, bit f, bit l);
		grid_point_t pt;
		pt.quantile = q;
		pt.prob = p;
		pt.missing = miss;
		pt.obs = x;
		pt.obs_prob = px;
		pt.first = f;
		pt.last = l;
		return pt;
	endfunction

	function automatic value_t pick_value();
		case ($urandom_range(0, 5))
			0: return V_MIN;
			1: return V_MAX;
			2, 3: return $urandom;
			default: return $urandom_range(0, 1 << 21) - (1 << 20);
		endcase
	endfunction

	function automatic grid_point_t noise_point();
		return make_point($urandom, prob_t'($urandom_range(0, PROB_TOP)),
			$urandom_range(0, 1) == 1, $urandom, prob_t'($urandom_range(0, PROB_TOP)),
			$urandom_range(0, 3) == 0, $urandom_range(0, 3) == 0);
	endfunction

	task automatic send_point(grid_point_t pt);
		int gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 4) == 0) ? 0 : $urandom_range(1, 20);
			burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 120)
				: $urandom_range(1, 12);
			if (gap > 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		{grid_quantile, grid_prob, prob_missing, observation, obs_cdf, first_point,
			last_point} <= pt;
		in_valid <= 1'b1;
		do
			@(posedge clk);
		while (!(in_valid && !in_stall));
		points_sent++;
	endtask

	// Holds the sender back until every outstanding score has been delivered.
	// It first waits on the clock so that the monitor has recorded the item just taken.
	task automatic drain_results();
		in_valid <= 1'b0;
		@(posedge clk);
		while (tracker.pending_scores.size() != 0)
			@(posedge clk);
	endtask

	// An item that produces no score may still be in flight after the queue empties.
	task automatic quiesce();
		in_valid <= 1'b0;
		@(posedge clk);
		while (tracker.pending_scores.size() != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic write_mode(bit trap);
		quiesce();
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= trap;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		tracker.trapezoid = trap;
	endtask

	task automatic directed_points();
		// Starts without a first point, so the bin opens at the previous (first run: reset) state.
		send_point(make_point(2 * ONE_Q, prob_t'(32768), 1'b0, ONE_Q, prob_t'(16384),
			1'b0, 1'b1));
		send_point(make_point(-ONE_Q, prob_t'(65536), 1'b0, 3 * ONE_Q, prob_t'(65536),
			1'b1, 1'b1));
		// Missing probability, probability above one, observation below the grid.
		send_point(make_point('0, prob_t'(0), 1'b0, -2 * ONE_Q, prob_t'(0), 1'b1, 1'b0));
		send_point(make_point(ONE_Q, prob_t'(20000), 1'b1, -2 * ONE_Q, prob_t'(0),
			1'b0, 1'b0));
		send_point(make_point(2 * ONE_Q, prob_t'(PROB_TOP), 1'b0, -2 * ONE_Q, prob_t'(0),
			1'b0, 1'b0));
		send_point(make_point(3 * ONE_Q, prob_t'(65536), 1'b0, -2 * ONE_Q, prob_t'(0),
			1'b0, 1'b1));
		// Descending quantiles drive the score negative.
		send_point(make_point(5 * ONE_Q, prob_t'(60000), 1'b0, 3 * ONE_Q,
			prob_t'(PROB_TOP), 1'b1, 1'b0));
		send_point(make_point(-3 * ONE_Q, prob_t'(10000), 1'b0, 3 * ONE_Q,
			prob_t'(40000), 1'b0, 1'b1));
		// Full-range widths drive the score to its upper limit.
		send_point(make_point(V_MIN, prob_t'(0), 1'b0, V_MAX, prob_t'(65536), 1'b1, 1'b0));
		send_point(make_point(V_MAX, prob_t'(65536), 1'b0, V_MAX, prob_t'(65536),
			1'b0, 1'b1));
		send_point(make_point(V_MAX, prob_t'(0), 1'b0, V_MIN, prob_t'(PROB_TOP),
			1'b1, 1'b0));
		send_point(make_point(V_MIN, prob_t'(PROB_TOP), 1'b0, V_MIN, prob_t'(0),
			1'b0, 1'b1));
	endtask

	task automatic random_forecast();
		value_t qs[16];
		prob_t  ps[16];
		int     n;
		int     acc;
		value_t x;
		prob_t  px;
		bit     roving;
		bit     drop_first;
		bit     drop_last;
		n = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 16) : $urandom_range(1, 8);
		qs[0] = $urandom_range(0, 1 << 22) - (1 << 21);
		ps[0] = prob_t'($urandom_range(0, UNIT_INT / 4));
		for (int i = 1; i < n; i++) begin
			qs[i] = qs[i-1] + (($urandom_range(0, 7) == 0) ? 0 : $urandom_range(1, 1 << 18));
			acc = ps[i-1] + $urandom_range(0, UNIT_INT / n);
			ps[i] = (acc > UNIT_INT) ? prob_t'(UNIT_INT) : prob_t'(acc);
			if ($urandom_range(0, 29) == 0)
				ps[i] = prob_t'($urandom_range(0, PROB_TOP));
		end
		case ($urandom_range(0, 4))
			0: x = qs[0] - $urandom_range(1, 1 << 19);
			1: x = qs[n-1] + $urandom_range(1, 1 << 19);
			2: x = qs[$urandom_range(0, n - 1)];
			default: x = qs[0] + $urandom_range(0, qs[n-1] - qs[0]);
		endcase
		px = ($urandom_range(0, 19) == 0) ? prob_t'($urandom_range(0, PROB_TOP))
			: prob_t'($urandom_range(0, UNIT_INT));
		roving = ($urandom_range(0, 15) == 0);
		drop_first = ($urandom_range(0, 19) == 0);
		drop_last = ($urandom_range(0, 19) == 0);
		for (int i = 0; i < n; i++)
			send_point(make_point(qs[i], ps[i], $urandom_range(0, 9) == 0,
				roving ? pick_value() : x, px, i == 0 && !drop_first,
				i == n - 1 && !drop_last));
	endtask

	task automatic random_phase(int count);
		int start;
		start = points_sent;
		while (points_sent - start < count) begin
			if ($urandom_range(0, 99) == 0)
				drain_results();
			if ($urandom_range(0, 9) < 8)
				random_forecast();
			else
				repeat ($urandom_range(1, 4)) send_point(noise_point());
		end
	endtask

	initial begin
		tracker = new();
		arst_n <= 1'b0;
		cfg_wr_en <= 1'b0;
		cfg_wr_data <= 1'b0;
		in_valid <= 1'b0;
		{grid_quantile, grid_prob, prob_missing, observation, obs_cdf, first_point,
			last_point} <= '0;
		out_stall <= 1'b0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		directed_points();
		write_mode(1'b0);
		directed_points();

		for (int phase = 0; phase < 4; phase++) begin
			write_mode(phase % 2 == 0);
			random_phase(250);
			drain_results();
			random_phase(250);
		end

		quiesce();
		if (tracker.mismatches == 0 && tracker.pending_scores.size() == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule
